@@ design/point_list_nearest_engine_macros.svh @@
// Assertion macros for the point table engine.
// Depends on nothing; included by the modules that carry checks.
`ifndef POINT_LIST_NEAREST_ENGINE_MACROS_SVH
`define POINT_LIST_NEAREST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define PLNE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point table check failed");
// Next-cycle implication
`define PLNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point table check failed");
`else
`define PLNE_ASSERT_SAME(label, clk, rst, ante, cons)
`define PLNE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ design/plne_pkg.sv @@
// Shared types and constants for the point table with nearest-point search.
// No dependencies; imported by plne_dist and point_list_nearest_engine.
package plne_pkg;

  // Default sizes
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 16;

  // Fixed field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STS_W   = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEAREST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LENGTH   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_FWD = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUMP_BWD = 3'd5;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY    = 2'd3;

  // Command beat
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic [FIELD_W-1:0] target_id;
  } plne_op_t;

  // Result beat
  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [FIELD_W-1:0] entry_id;
    logic [FIELD_W-1:0] entry_x;
    logic [FIELD_W-1:0] entry_y;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } plne_res_t;

  // Tag that travels with an entry through the distance stage
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } plne_tag_t;

endpackage

@@ design/plne_dist.sv @@
// Registered squared-distance stage for the nearest-point scan.
// Depends on plne_pkg (tag type, default sizes).
module plne_dist #(
  parameter int unsigned COORD_W = plne_pkg::DEF_COORD_BITS,
  parameter int unsigned ENTRY_W = plne_pkg::FIELD_W + 2 * plne_pkg::DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  plne_pkg::plne_tag_t   tag_in,
  input  logic [ENTRY_W-1:0]    ent_in,
  input  logic [COORD_W-1:0]    qx,
  input  logic [COORD_W-1:0]    qy,
  output plne_pkg::plne_tag_t   tag_out,
  output logic [ENTRY_W-1:0]    ent_out,
  output logic [2*COORD_W-1:0]  sq_x,
  output logic [2*COORD_W-1:0]  sq_y
);
  import plne_pkg::*;

  logic [COORD_W-1:0] ex, ey, dx, dy;

  // Absolute coordinate differences
  always_comb begin
    ex = ent_in[2*COORD_W-1 -: COORD_W];
    ey = ent_in[COORD_W-1:0];
    dx = (ex > qx) ? (ex - qx) : (qx - ex);
    dy = (ey > qy) ? (ey - qy) : (qy - ey);
  end

  // Squares registered, entry and tag carried alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    ent_out <= ent_in;
    sq_x    <= {{COORD_W{1'b0}}, dx} * {{COORD_W{1'b0}}, dx};
    sq_y    <= {{COORD_W{1'b0}}, dy} * {{COORD_W{1'b0}}, dy};
  end

endmodule

@@ design/point_list_nearest_engine.sv @@
// Ordered point table: append, delete with compaction, nearest, length, dump.
// Depends on plne_pkg, plne_dist and point_list_nearest_engine_macros.svh.
//
//  channel  | handshake              | payload          | beats per command
//  ---------+------------------------+------------------+------------------
//  command  | start high, busy low   | op  (plne_op_t)  | 1
//  result   | res_strobe, one cycle  | res (plne_res_t) | 0, 1 or up to n
//
// Append, length, unused codes and any command on an empty table finish in
// the accept cycle; busy never rises. Unused codes give no result, the rest
// a registered one in the next cycle. Nearest, dump (one result per cycle)
// and delete (search, then compaction) walk the table, one entry per cycle,
// set by the single read port of the entry memory. Reset empties the table.
// The receiver cannot stall; results are never held back.
module point_list_nearest_engine #(
  parameter int unsigned TABLE_DEPTH = plne_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = plne_pkg::DEF_COORD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  plne_pkg::plne_op_t  op,
  output logic                res_strobe,
  output plne_pkg::plne_res_t res
);
  import plne_pkg::*;
  `include "point_list_nearest_engine_macros.svh"

  localparam int unsigned CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned EW    = FIELD_W + 2 * CW;
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW    = 2 * CW + 1;
  localparam int unsigned ID_HI = EW - 1;
  localparam int unsigned X_HI  = 2 * CW - 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

  state_t               state;
  logic [CNTW-1:0]      count;
  logic [FIELD_W-1:0]   next_id;

  // Latched command
  logic [CMD_W-1:0]     op_cmd;
  logic [CNTW-1:0]      op_n;
  logic [FIELD_W-1:0]   op_tid;
  logic [CW-1:0]        qx, qy;

  // Read walk
  logic [CNTW-1:0]      iss_cnt;
  logic [CNTW-1:0]      back_idx;
  logic                 iss_en;
  logic [AW-1:0]        iss_addr;
  logic                 rd_valid;
  logic [AW-1:0]        rd_idx;
  logic                 rd_last;
  logic [EW-1:0]        rdata;
  logic [FIELD_W-1:0]   rd_id;

  // Entry memory
  logic [EW-1:0]        mem [TABLE_DEPTH];
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [EW-1:0]        wr_data;

  // Distance stage and best-so-far
  plne_tag_t            d_tag_in, d_tag;
  logic [EW-1:0]        d_ent;
  logic [2*CW-1:0]      sq_x, sq_y;
  logic [SW-1:0]        d_sum;
  logic                 d_better;
  logic [EW-1:0]        win_ent;
  logic [SW-1:0]        best_sum;
  logic [EW-1:0]        best_ent;

  logic                 accept;
  logic                 full;
  logic                 del_hit;

  function automatic plne_res_t make_res(input logic [STS_W-1:0]   st,
                                         input logic [FIELD_W-1:0] id,
                                         input logic [CW-1:0]      x,
                                         input logic [CW-1:0]      y,
                                         input logic [CNTW-1:0]    cnt,
                                         input logic               lst);
    plne_res_t r;
    r.status      = st;
    r.entry_id    = id;
    r.entry_x     = FIELD_W'(x);
    r.entry_y     = FIELD_W'(y);
    r.entry_count = COUNT_W'(cnt);
    r.last        = lst;
    return r;
  endfunction

  assign busy = (state != ST_IDLE);

  // Read issue, match detect and write port steering
  always_comb begin
    accept   = start && !busy;
    full     = (count == CNTW'(TABLE_DEPTH));
    back_idx = op_n - CNTW'(1) - iss_cnt;
    iss_en   = (state != ST_IDLE) && (iss_cnt < op_n);
    iss_addr = (op_cmd == CMD_DUMP_BWD) ? back_idx[AW-1:0] : iss_cnt[AW-1:0];
    rd_id    = rdata[ID_HI -: FIELD_W];
    del_hit  = (state == ST_WALK) && (op_cmd == CMD_DELETE) && rd_valid &&
               (rd_id == op_tid);
    wr_en    = 1'b0;
    wr_addr  = count[AW-1:0];
    wr_data  = {next_id, op.px[CW-1:0], op.py[CW-1:0]};
    if (accept && (op.cmd == CMD_APPEND) && !full) begin
      wr_en = 1'b1;
    end else if ((state == ST_SHIFT) && rd_valid) begin
      // compaction: reads run one ahead of writes, addresses never meet
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
      wr_data = rdata;
    end
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (iss_en) begin
      rdata <= mem[iss_addr];
    end
  end

  // Distance stage feed
  always_comb begin
    d_tag_in.valid = rd_valid && (state == ST_WALK) && (op_cmd == CMD_NEAREST);
    d_tag_in.first = (rd_idx == '0);
    d_tag_in.last  = rd_last;
  end

  plne_dist #(
    .COORD_W (CW),
    .ENTRY_W (EW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (d_tag_in),
    .ent_in  (rdata),
    .qx      (qx),
    .qy      (qy),
    .tag_out (d_tag),
    .ent_out (d_ent),
    .sq_x    (sq_x),
    .sq_y    (sq_y)
  );

  // Compare against best; strict less keeps the earliest on a tie
  always_comb begin
    d_sum    = {1'b0, sq_x} + {1'b0, sq_y};
    d_better = d_tag.first || (d_sum < best_sum);
    win_ent  = d_better ? d_ent : best_ent;
  end

  // Command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd <= op.cmd;
      op_n   <= count;
      op_tid <= op.target_id;
      qx     <= op.px[CW-1:0];
      qy     <= op.py[CW-1:0];
    end
  end

  // Control, walk bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      next_id    <= FIELD_W'(1);
      res_strobe <= 1'b0;
      rd_valid   <= 1'b0;
      iss_cnt    <= '0;
    end else begin
      res_strobe <= 1'b0;
      rd_valid   <= iss_en;
      rd_idx     <= iss_cnt[AW-1:0];
      rd_last    <= (iss_cnt == op_n - CNTW'(1));
      if (iss_en) begin
        iss_cnt <= iss_cnt + CNTW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (op.cmd) inside
              CMD_APPEND: begin
                res_strobe <= 1'b1;
                if (full) begin
                  res <= make_res(STS_FULL, '0, '0, '0, count, 1'b1);
                end else begin
                  res     <= make_res(STS_OK, next_id, op.px[CW-1:0], op.py[CW-1:0],
                                      count + CNTW'(1), 1'b1);
                  count   <= count + CNTW'(1);
                  next_id <= next_id + FIELD_W'(1);
                end
              end
              CMD_LENGTH: begin
                res_strobe <= 1'b1;
                res        <= make_res(STS_OK, '0, '0, '0, count, 1'b1);
              end
              CMD_DELETE, CMD_NEAREST, CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                if (count == '0) begin
                  res_strobe <= 1'b1;
                  res        <= make_res(STS_EMPTY, '0, '0, '0, count, 1'b1);
                end else begin
                  iss_cnt <= '0;
                  state   <= ST_WALK;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (op_cmd == CMD_DELETE) begin
            // search; on a hit report at once, then compact the tail
            if (del_hit) begin
              res_strobe <= 1'b1;
              res        <= make_res(STS_OK, op_tid, rdata[X_HI -: CW], rdata[CW-1:0],
                                     op_n - CNTW'(1), 1'b1);
              count      <= count - CNTW'(1);
              state      <= rd_last ? ST_IDLE : ST_SHIFT;
            end else if (rd_valid && rd_last) begin
              res_strobe <= 1'b1;
              res        <= make_res(STS_NOTFOUND, op_tid, '0, '0, op_n, 1'b1);
              state      <= ST_IDLE;
            end
          end else if (op_cmd == CMD_NEAREST) begin
            if (d_tag.valid) begin
              best_sum <= d_better ? d_sum : best_sum;
              best_ent <= win_ent;
              if (d_tag.last) begin
                res_strobe <= 1'b1;
                res        <= make_res(STS_OK, win_ent[ID_HI -: FIELD_W],
                                       win_ent[X_HI -: CW], win_ent[CW-1:0], op_n, 1'b1);
                state      <= ST_IDLE;
              end
            end
          end else begin
            // dump: one beat per entry read
            if (rd_valid) begin
              res_strobe <= 1'b1;
              res        <= make_res(STS_OK, rd_id, rdata[X_HI -: CW], rdata[CW-1:0],
                                     op_n, rd_last);
              if (rd_last) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_SHIFT: begin
          if (rd_valid && rd_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `PLNE_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CNTW'(TABLE_DEPTH))
  `PLNE_ASSERT_SAME(a_idle_quiet, clk, rst, !busy, !rd_valid && !d_tag.valid)
  `PLNE_ASSERT_SAME(a_shift_no_overlap, clk, rst, wr_en && iss_en && (state == ST_SHIFT), wr_addr != iss_addr)
  `PLNE_ASSERT_NEXT(a_append_grows, clk, rst, accept && (op.cmd == CMD_APPEND) && !full, count == $past(count) + CNTW'(1))

endmodule

@@ sim/tb_point_list_nearest_engine.sv @@
`timescale 1ns / 100ps
// Self-checking bench for point_list_nearest_engine: directed table, then random traffic.
// Keeps its own image of the point table to predict result beats; typed rows give theirs.
// Depends on plne_pkg and the point_list_nearest_engine RTL.
module tb_point_list_nearest_engine;
  import plne_pkg::*;

  localparam int unsigned DEPTH        = DEF_TABLE_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;
  // undefined command codes, ignored by the block
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_SILENT} row_kind_t;

  typedef struct {
    plne_op_t  o;
    row_kind_t kind;
    plne_res_t want;
  } dir_row_t;

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      start      = 1'b0;
  plne_op_t  op         = '0;
  logic      busy;
  logic      res_strobe;
  plne_res_t res;

  // how the beat on op is to be checked, travels with op
  row_kind_t pin_kind = ROW_PRED;
  plne_res_t pin_res  = '0;

  // image of the point table
  logic [FIELD_W-1:0] tab_x  [DEPTH];
  logic [FIELD_W-1:0] tab_y  [DEPTH];
  logic [FIELD_W-1:0] tab_id [DEPTH];
  int unsigned        tab_fill    = 0;
  logic [FIELD_W-1:0] tab_next_id = 16'd1;

  plne_res_t   expected_beats[$];
  plne_res_t   got_want;
  int unsigned fails      = 0;
  int unsigned burst_left = 0;

  point_list_nearest_engine dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .res_strobe (res_strobe),
    .res        (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result beat with the count as it stands after the operation
  function automatic plne_res_t beat(logic [STS_W-1:0] s, logic [FIELD_W-1:0] id,
                                     logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic l);
    beat = '{status: s, entry_id: id, entry_x: x, entry_y: y,
             entry_count: COUNT_W'(tab_fill), last: l};
  endfunction

  // Apply one accepted command to the table image; queue its beats if asked.
  task automatic point_table_update(input plne_op_t o, input bit record);
    plne_res_t          outq[$];
    int unsigned        hit;
    int unsigned        best;
    int unsigned        e;
    longint unsigned    dx, dy, d, best_d;
    logic [FIELD_W-1:0] rx, ry;
    hit    = DEPTH;
    best   = 0;
    best_d = 0;
    case (o.cmd)
      CMD_APPEND: begin
        if (tab_fill >= DEPTH) begin
          outq.push_back(beat(STS_FULL, '0, '0, '0, 1'b1));
        end else begin
          tab_x[tab_fill]  = o.px;
          tab_y[tab_fill]  = o.py;
          tab_id[tab_fill] = tab_next_id;
          tab_fill++;
          outq.push_back(beat(STS_OK, tab_next_id, o.px, o.py, 1'b1));
          tab_next_id = tab_next_id + 16'd1;
        end
      end
      CMD_DELETE: begin
        if (tab_fill == 0) begin
          outq.push_back(beat(STS_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < tab_fill; i++)
            if (hit == DEPTH && tab_id[i] == o.target_id) hit = i;
          if (hit == DEPTH) begin
            outq.push_back(beat(STS_NOTFOUND, o.target_id, '0, '0, 1'b1));
          end else begin
            rx = tab_x[hit];
            ry = tab_y[hit];
            // close the gap, order kept
            for (int j = hit; j + 1 < tab_fill; j++) begin
              tab_x[j]  = tab_x[j+1];
              tab_y[j]  = tab_y[j+1];
              tab_id[j] = tab_id[j+1];
            end
            tab_fill--;
            outq.push_back(beat(STS_OK, o.target_id, rx, ry, 1'b1));
          end
        end
      end
      CMD_NEAREST: begin
        if (tab_fill == 0) begin
          outq.push_back(beat(STS_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          // squared distance; strict compare keeps the earliest on a tie
          for (int i = 0; i < tab_fill; i++) begin
            dx = (tab_x[i] > o.px) ? 64'(tab_x[i] - o.px) : 64'(o.px - tab_x[i]);
            dy = (tab_y[i] > o.py) ? 64'(tab_y[i] - o.py) : 64'(o.py - tab_y[i]);
            d  = dx * dx + dy * dy;
            if (i == 0 || d < best_d) begin
              best   = i;
              best_d = d;
            end
          end
          outq.push_back(beat(STS_OK, tab_id[best], tab_x[best], tab_y[best], 1'b1));
        end
      end
      CMD_LENGTH: outq.push_back(beat(STS_OK, '0, '0, '0, 1'b1));
      CMD_DUMP_FWD, CMD_DUMP_BWD: begin
        if (tab_fill == 0) begin
          outq.push_back(beat(STS_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < tab_fill; i++) begin
            e = (o.cmd == CMD_DUMP_FWD) ? i : tab_fill - 1 - i;
            outq.push_back(beat(STS_OK, tab_id[e], tab_x[e], tab_y[e], i + 1 == tab_fill));
          end
        end
      end
      default: ;
    endcase
    if (record) foreach (outq[k]) expected_beats.push_back(outq[k]);
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Monitor: check the result beat first, then predict the command accepted at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_strobe) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with none expected: 0x%0h", res);
          fails++;
        end else begin
          got_want = expected_beats.pop_front();
          check_field("status", got_want.status, res.status);
          check_field("entry_id", got_want.entry_id, res.entry_id);
          check_field("entry_x", got_want.entry_x, res.entry_x);
          check_field("entry_y", got_want.entry_y, res.entry_y);
          check_field("entry_count", got_want.entry_count, res.entry_count);
          check_field("last", got_want.last, res.last);
        end
      end
      if (start && !busy) begin
        point_table_update(op, pin_kind == ROW_PRED);
        if (pin_kind == ROW_TYPED) expected_beats.push_back(pin_res);
      end
    end
  end

  // Present one command beat and hold it until the edge that takes it.
  task automatic issue(input plne_op_t o, input row_kind_t k, input plne_res_t w);
    op       <= o;
    pin_kind <= k;
    pin_res  <= w;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length, gaps short or long enough to cover a whole walk
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause(($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4));
      burst_left = $urandom_range(0, 24);
    end
  endtask

  function automatic logic [FIELD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       pick_coord = '0;
      1:       pick_coord = '1;
      2, 3:    pick_coord = FIELD_W'($urandom_range(0, 3));  // tight cluster, forces ties
      default: pick_coord = FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic dir_row_t dir_row(row_kind_t k, logic [CMD_W-1:0] c,
                                       logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                       logic [FIELD_W-1:0] t, logic [STS_W-1:0] s,
                                       logic [FIELD_W-1:0] id, logic [FIELD_W-1:0] ex,
                                       logic [FIELD_W-1:0] ey, logic [COUNT_W-1:0] cnt);
    dir_row_t r;
    r.o    = '{cmd: c, px: x, py: y, target_id: t};
    r.kind = k;
    r.want = '{status: s, entry_id: id, entry_x: ex, entry_y: ey, entry_count: cnt,
               last: 1'b1};
    return r;
  endfunction

  // Stimulus
  initial begin
    dir_row_t           dir_tab[$];
    plne_op_t           o;
    int unsigned        done_items;
    int unsigned        w;
    int unsigned        idx;

    // empty table: length gives 0, every command that walks it reports empty
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_LENGTH, 0, 0, 0, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_DELETE, 0, 0, 1, STS_EMPTY, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_NEAREST, 16'hFFFF, 0, 0, STS_EMPTY, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_DUMP_FWD, 0, 0, 0, STS_EMPTY, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_DUMP_BWD, 0, 0, 0, STS_EMPTY, 0, 0, 0, 0));
    // undefined codes give nothing
    dir_tab.push_back(dir_row(ROW_SILENT, CMD_SPARE_6, '1, '1, '1, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_SILENT, CMD_SPARE_7, '1, '1, '1, STS_OK, 0, 0, 0, 0));
    // appends at the coordinate extremes, ids from 1
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_APPEND, 0, 0, '1, STS_OK, 1, 0, 0, 1));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_APPEND, '1, '1, 0, STS_OK, 2, '1, '1, 2));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_APPEND, 16'h8000, 16'h0001, 0,
                              STS_OK, 3, 16'h8000, 16'h0001, 3));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_NEAREST, '1, '1, 0, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_NEAREST, 0, 0, 0, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_NEAREST, 16'h8000, 16'h8000, 0,
                              STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_APPEND, 16'h1000, 16'h1000, 0,
                              STS_OK, 4, 16'h1000, 16'h1000, 4));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_APPEND, 16'h3000, 16'h3000, 0,
                              STS_OK, 5, 16'h3000, 16'h3000, 5));
    // equidistant from two entries: the earlier one wins
    dir_tab.push_back(dir_row(ROW_PRED, CMD_NEAREST, 16'h2000, 16'h2000, 0,
                              STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DUMP_FWD, 0, 0, 0, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DUMP_BWD, 0, 0, 0, STS_OK, 0, 0, 0, 0));
    // no match: id echoed
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_DELETE, 0, 0, 16'h0063,
                              STS_NOTFOUND, 16'h0063, 0, 0, 5));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_DELETE, '1, '1, '1, STS_NOTFOUND, '1, 0, 0, 5));
    // head, tail, middle
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DELETE, 0, 0, 1, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DELETE, 0, 0, 5, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DELETE, 0, 0, 3, STS_OK, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(ROW_TYPED, CMD_LENGTH, 0, 0, 0, STS_OK, 0, 0, 0, 2));
    dir_tab.push_back(dir_row(ROW_PRED, CMD_DUMP_FWD, 0, 0, 0, STS_OK, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) begin
      issue(dir_tab[k].o, dir_tab[k].kind, dir_tab[k].want);
      pace();
    end

    // random traffic: mixed, then a fill past full, then a drain
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      o.px        = pick_coord();
      o.py        = pick_coord();
      o.target_id = FIELD_W'($urandom_range(0, 65535));
      w           = $urandom_range(0, 99);
      if (done_items >= 40 && done_items < 140 && w < 75)       o.cmd = CMD_APPEND;
      else if (done_items >= 140 && done_items < 190 && w < 70) o.cmd = CMD_DELETE;
      else if (w < 30) o.cmd = CMD_APPEND;
      else if (w < 48) o.cmd = CMD_DELETE;
      else if (w < 63) o.cmd = CMD_NEAREST;
      else if (w < 70) o.cmd = CMD_LENGTH;
      else if (w < 79) o.cmd = CMD_DUMP_FWD;
      else if (w < 88) o.cmd = CMD_DUMP_BWD;
      else if (w < 94) o.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      else             o.cmd = CMD_APPEND;
      // mostly delete ids that are present
      if (o.cmd == CMD_DELETE && tab_fill > 0 && $urandom_range(0, 4) != 0)
        o.target_id = tab_id[$urandom_range(0, tab_fill - 1)];
      // some queries land exactly on a stored point
      if (o.cmd == CMD_NEAREST && tab_fill > 0 && $urandom_range(0, 3) == 0) begin
        idx  = $urandom_range(0, tab_fill - 1);
        o.px = tab_x[idx];
        o.py = tab_y[idx];
      end
      issue(o, ROW_PRED, '0);
      if (o.cmd != CMD_SPARE_6 && o.cmd != CMD_SPARE_7) done_items++;
      pace();
    end

    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_point_list_nearest_engine: done, clean");
    end else begin
      $display("tb_point_list_nearest_engine: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("tb_point_list_nearest_engine: done, errors");
    $finish;
  end

endmodule

@@ point_list_nearest_engine.f @@
+incdir+design
design/plne_pkg.sv
design/plne_dist.sv
design/point_list_nearest_engine.sv
sim/tb_point_list_nearest_engine.sv
